FILE: hdl/triangle_scan_rasterizer_defines.svh
// Assertion macros for the rasterizer RTL
`ifndef TRIANGLE_SCAN_RASTERIZER_DEFINES_SVH
`define TRIANGLE_SCAN_RASTERIZER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define TSR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hdl/tsr_pkg.sv
// Shared constants, codes and types of the triangle rasterizer
package tsr_pkg;

    localparam int COORD_INT_BITS  = 12;
    localparam int COORD_FRAC_BITS = 4;
    localparam int COLOR_W         = 24;
    localparam int CFG_DATA_W      = 24;
    localparam int REG_IDX_W       = 3;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_VERTEX_A_X = 3'd0,
        REG_VERTEX_A_Y = 3'd1,
        REG_VERTEX_B_X = 3'd2,
        REG_VERTEX_B_Y = 3'd3,
        REG_VERTEX_C_X = 3'd4,
        REG_VERTEX_C_Y = 3'd5,
        REG_FILL_COLOR = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMIT,
        ST_GEOM,
        ST_CLAMP,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_FIX,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic start;
    } q_item_t;

endpackage

FILE: hdl/tsr_if.sv
// Channel interfaces: request, pixel result and configuration write

interface tsr_req_if;
    logic valid;
    logic ready;
    logic start_req;
    modport source (output valid, output start_req, input ready);
    modport sink (input valid, input start_req, output ready);
endinterface

interface tsr_pix_if #(
    parameter int PIX_W = tsr_pkg::COORD_INT_BITS
);
    logic                            valid;
    logic                            ready;
    logic signed [PIX_W-1:0]         pixel_x;
    logic signed [PIX_W-1:0]         pixel_y;
    logic [tsr_pkg::COLOR_W-1:0]     color;
    logic                            last_pixel;
    modport source (output valid, output pixel_x, output pixel_y, output color,
                    output last_pixel, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input color,
                  input last_pixel, output ready);
endinterface

interface tsr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tsr_pkg::REG_IDX_W-1:0]      index;
    logic [tsr_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/triangle_scan_rasterizer.sv
// Top level of the triangle scanline rasterizer
//
// Each request on req yields at most one pixel on pix; a request with
// start_req set restarts the walk. Requests queue two deep ahead of the walk
// engine, and the pixel output register lets the next request be taken while
// a pixel waits. A request that steps to the next row of the same column
// passes through the emit and output states. Moving to a new column evaluates
// the lower and then the upper edge, each with a multiply, an add and a
// restoring divide of NW = 2*(COORD_INT_BITS + COORD_FRAC_BITS)+5 bits,
// after a clamp step for the column. Loading a half's geometry is a step of
// its own each time a search starts, leaves a column or moves on to the
// next half, and a skipped half takes a geometry load and a clamp step.
// Configuration writes are taken every cycle.
module triangle_scan_rasterizer #(
    parameter int COORD_INT_BITS  = tsr_pkg::COORD_INT_BITS,
    parameter int COORD_FRAC_BITS = tsr_pkg::COORD_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    tsr_req_if.sink     req,
    tsr_pix_if.source   pix,
    tsr_cfg_if.sink     cfg
);
    import tsr_pkg::*;

    logic     q_valid;
    logic     q_ready;
    q_item_t  q_item;

    tsr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready)
    );

    tsr_back #(
        .COORD_INT_BITS  (COORD_INT_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready),
        .cfg     (cfg),
        .pix     (pix)
    );

endmodule

FILE: hdl/tsr_front.sv
// Request front end: accepts requests into a two-entry queue
module tsr_front (
    input  logic              clk,
    input  logic              rst_n,
    tsr_req_if.sink           req,
    output logic              q_valid,
    output tsr_pkg::q_item_t  q_item,
    input  logic              q_ready
);
    import tsr_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    q_item_t          q_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             push, pop;

    assign req.ready = (count_reg != CNTW'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_valid && q_ready;
    assign q_item    = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].start <= req.start_req;
        end
    end

endmodule

FILE: hdl/tsr_div.sv
// Restoring divider, one quotient bit per cycle
module tsr_div #(
    parameter int NW = 37,
    parameter int DW = 21
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [NW-1:0]  dividend,
    input  logic [DW-1:0]  divisor,
    output logic           busy,
    output logic [NW-1:0]  quo,
    output logic           rem_nz
);
    localparam int CNTW = $clog2(NW + 1);

    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   dvs_reg;
    logic [DW:0]     shifted;
    logic [DW:0]     diff;
    logic            ge;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next  = CNTW'(NW);
            busy_next = 1'b1;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_next  = {quo_reg[NW-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNTW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy   = busy_reg;
    assign quo    = quo_reg;
    assign rem_nz = |rem_reg;

endmodule

FILE: hdl/tsr_back.sv
// Walk engine: config registers, triangle setup, column scan and pixel output
`include "triangle_scan_rasterizer_defines.svh"

module tsr_back #(
    parameter int COORD_INT_BITS  = tsr_pkg::COORD_INT_BITS,
    parameter int COORD_FRAC_BITS = tsr_pkg::COORD_FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  tsr_pkg::q_item_t  q_item,
    output logic              q_ready,
    tsr_cfg_if.sink           cfg,
    tsr_pix_if.source         pix
);
    import tsr_pkg::*;

    localparam int CI   = COORD_INT_BITS;
    localparam int FB   = COORD_FRAC_BITS;
    localparam int CW   = CI + FB;
    localparam int COLW = CI + 2;
    localparam int TW   = CW + 3;
    localparam int P1W  = 2 * CW + 1;
    localparam int P2W  = 2 * CW + 4;
    localparam int NW   = 2 * CW + 5;
    localparam int RW   = NW + 1;
    localparam int DW   = CW + FB + 1;

    // config registers
    logic signed [CW-1:0]  vx_reg [3];
    logic signed [CW-1:0]  vy_reg [3];
    logic [COLOR_W-1:0]    color_reg;

    back_state_t           state_reg, state_next;
    logic                  h_reg, h_next;
    logic signed [COLW-1:0] col_reg, col_next;
    logic signed [RW-1:0]  row_reg, row_next;
    logic signed [RW-1:0]  limit_reg, limit_next;
    logic                  active_reg, active_next;
    logic                  low_start_reg, low_start_next;
    logic                  adv_reg, adv_next;
    logic                  sel_reg, sel_next;
    logic                  g_ok_reg;
    logic signed [COLW-1:0] g_lo_reg, g_hi_reg;
    logic signed [CW-1:0]  e_reg [2][4];
    logic signed [P1W-1:0] p1_reg;
    logic signed [P2W-1:0] p2_reg;
    logic signed [CW:0]    dx_reg;
    logic                  neg_reg;
    logic signed [RW-1:0]  lo_reg, lo_next;
    logic [CI-1:0]         px_x_reg, px_x_next;
    logic [CI-1:0]         px_y_reg, px_y_next;
    logic                  last_reg, last_next;
    logic                  ov_reg, ov_next;
    logic [CI-1:0]         ox_reg, oy_reg;
    logic [COLOR_W-1:0]    oc_reg;
    logic                  ol_reg;
    logic                  out_load;

    // setup of the current half
    logic signed [CW-1:0]  ax, ay, bx, by, cx, cy;
    logic                  up;
    logic                  g_ok_c;
    logic signed [COLW-1:0] g_lo_c, g_hi_c;
    logic signed [CW-1:0]  e_c [2][4];

    // per-column arithmetic
    logic signed [CW-1:0]  ex0, ey0, ex1, ey1;
    logic signed [CW:0]    dx_c, dy_c;
    logic signed [TW-1:0]  t_c;
    logic signed [NW-1:0]  n_c;
    logic [NW-1:0]         abs_n;
    logic                  div_start, div_busy, div_rem_nz;
    logic [NW-1:0]         div_quo;
    logic signed [RW-1:0]  qe;
    logic signed [RW-1:0]  fl_q, ce_q;
    logic signed [COLW-1:0] col_c;
    logic                  skip_half;

    function automatic logic signed [COLW-1:0] flr(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] s;
        s = v >>> FB;
        return COLW'(s);
    endfunction

    function automatic logic signed [COLW-1:0] ceil_f(input logic signed [CW-1:0] v);
        logic signed [CW:0] nv;
        logic signed [CW:0] s;
        nv = -(CW + 1)'(v);
        s = nv >>> FB;
        return -COLW'(s);
    endfunction

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg[0] <= '0;
            vx_reg[1] <= '0;
            vx_reg[2] <= '0;
            vy_reg[0] <= '0;
            vy_reg[1] <= '0;
            vy_reg[2] <= '0;
            color_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_VERTEX_A_X: vx_reg[0] <= cfg.data[CW-1:0];
                REG_VERTEX_A_Y: vy_reg[0] <= cfg.data[CW-1:0];
                REG_VERTEX_B_X: vx_reg[1] <= cfg.data[CW-1:0];
                REG_VERTEX_B_Y: vy_reg[1] <= cfg.data[CW-1:0];
                REG_VERTEX_C_X: vx_reg[2] <= cfg.data[CW-1:0];
                REG_VERTEX_C_Y: vy_reg[2] <= cfg.data[CW-1:0];
                REG_FILL_COLOR: color_reg <= cfg.data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // leftmost vertex first, then split into halves
    always_comb
    begin
        ax = vx_reg[0]; ay = vy_reg[0];
        bx = vx_reg[1]; by = vy_reg[1];
        cx = vx_reg[2]; cy = vy_reg[2];
        if (vx_reg[1] < vx_reg[2] && vx_reg[1] < vx_reg[0])
        begin
            ax = vx_reg[1]; ay = vy_reg[1];
            bx = vx_reg[2]; by = vy_reg[2];
            cx = vx_reg[0]; cy = vy_reg[0];
        end
        else if (vx_reg[2] < vx_reg[1] && vx_reg[2] < vx_reg[0])
        begin
            ax = vx_reg[2]; ay = vy_reg[2];
            bx = vx_reg[0]; by = vy_reg[0];
            cx = vx_reg[1]; cy = vy_reg[1];
        end
        up = (cx < bx);
        if (!h_reg)
        begin
            g_ok_c = up ? (ax != cx) : (ax != bx && ax != cx);
            g_lo_c = ceil_f(ax);
            g_hi_c = flr(up ? cx : bx);
            e_c[0][0] = ax; e_c[0][1] = ay; e_c[0][2] = bx; e_c[0][3] = by;
            e_c[1][0] = ax; e_c[1][1] = ay; e_c[1][2] = cx; e_c[1][3] = cy;
        end
        else
        begin
            g_ok_c = up ? 1'b1 : (bx != cx);
            g_lo_c = flr(up ? cx : bx) + COLW'(1);
            g_hi_c = flr(up ? bx : cx);
            if (up)
            begin
                e_c[0][0] = ax; e_c[0][1] = ay; e_c[0][2] = bx; e_c[0][3] = by;
                e_c[1][0] = cx; e_c[1][1] = cy; e_c[1][2] = bx; e_c[1][3] = by;
            end
            else
            begin
                e_c[0][0] = bx; e_c[0][1] = by; e_c[0][2] = cx; e_c[0][3] = cy;
                e_c[1][0] = ax; e_c[1][1] = ay; e_c[1][2] = cx; e_c[1][3] = cy;
            end
        end
        if (e_c[0][2] <= e_c[0][0] || e_c[1][2] <= e_c[1][0])
        begin
            g_ok_c = 1'b0;
        end
    end

    assign ex0  = e_reg[sel_reg][0];
    assign ey0  = e_reg[sel_reg][1];
    assign ex1  = e_reg[sel_reg][2];
    assign ey1  = e_reg[sel_reg][3];
    assign dx_c = (CW + 1)'(ex1) - (CW + 1)'(ex0);
    assign dy_c = (CW + 1)'(ey1) - (CW + 1)'(ey0);
    assign t_c  = (TW'(col_reg) <<< FB) - TW'(ex0);
    assign n_c  = NW'(p1_reg) + NW'(p2_reg);
    assign abs_n = n_c[NW-1] ? NW'(-n_c) : NW'(n_c);

    assign qe   = RW'({1'b0, div_quo});
    assign fl_q = neg_reg ? -(qe + RW'(div_rem_nz)) : qe;
    assign ce_q = neg_reg ? -qe : (qe + RW'(div_rem_nz));

    assign col_c     = (low_start_reg || col_reg < g_lo_reg) ? g_lo_reg : col_reg;
    assign skip_half = !g_ok_reg || (col_c > g_hi_reg);
    assign out_load  = (state_reg == ST_OUT) && (!ov_reg || pix.ready);

    tsr_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (abs_n),
        .divisor  (DW'(dx_reg) << FB),
        .busy     (div_busy),
        .quo      (div_quo),
        .rem_nz   (div_rem_nz)
    );

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        limit_next     = limit_reg;
        active_next    = active_reg;
        low_start_next = low_start_reg;
        adv_next       = adv_reg;
        sel_next       = sel_reg;
        lo_next        = lo_reg;
        px_x_next      = px_x_reg;
        px_y_next      = px_y_reg;
        last_next      = last_reg;
        ov_next        = ov_reg && !pix.ready;
        q_ready        = 1'b0;
        div_start      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_ready = 1'b1;
                    if (q_item.start)
                    begin
                        h_next         = 1'b0;
                        low_start_next = 1'b1;
                        adv_next       = 1'b0;
                        active_next    = 1'b0;
                        state_next     = ST_GEOM;
                    end
                    else if (active_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                px_x_next = col_reg[CI-1:0];
                px_y_next = row_reg[CI-1:0];
                if (row_reg < limit_reg)
                begin
                    row_next   = row_reg + RW'(1);
                    last_next  = 1'b0;
                    state_next = ST_OUT;
                end
                else
                begin
                    adv_next       = 1'b1;
                    active_next    = 1'b0;
                    col_next       = col_reg + COLW'(1);
                    low_start_next = 1'b0;
                    state_next     = ST_GEOM;
                end
            end
            ST_GEOM:
            begin
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if (skip_half)
                begin
                    if (h_reg)
                    begin
                        if (adv_reg)
                        begin
                            last_next  = 1'b1;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        h_next         = 1'b1;
                        low_start_next = 1'b1;
                        state_next     = ST_GEOM;
                    end
                end
                else
                begin
                    col_next   = col_c;
                    sel_next   = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                if (!sel_reg)
                begin
                    lo_next    = ce_q;
                    sel_next   = 1'b1;
                    state_next = ST_MUL;
                end
                else if (lo_reg <= fl_q)
                begin
                    row_next    = lo_reg;
                    limit_next  = fl_q;
                    active_next = 1'b1;
                    if (adv_reg)
                    begin
                        last_next  = 1'b0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    col_next       = col_reg + COLW'(1);
                    low_start_next = 1'b0;
                    state_next     = ST_CLAMP;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || pix.ready)
                begin
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            h_reg         <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            limit_reg     <= '0;
            active_reg    <= 1'b0;
            low_start_reg <= 1'b0;
            adv_reg       <= 1'b0;
            sel_reg       <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            limit_reg     <= limit_next;
            active_reg    <= active_next;
            low_start_reg <= low_start_next;
            adv_reg       <= adv_next;
            sel_reg       <= sel_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        px_x_reg <= px_x_next;
        px_y_reg <= px_y_next;
        last_reg <= last_next;
        if (state_reg == ST_GEOM)
        begin
            g_ok_reg <= g_ok_c;
            g_lo_reg <= g_lo_c;
            g_hi_reg <= g_hi_c;
            e_reg    <= e_c;
        end
        if (state_reg == ST_MUL)
        begin
            p1_reg <= P1W'(ey0) * P1W'(dx_c);
            p2_reg <= P2W'(dy_c) * P2W'(t_c);
            dx_reg <= dx_c;
        end
        if (state_reg == ST_SUM)
        begin
            neg_reg <= n_c[NW-1];
        end
        if (out_load)
        begin
            ox_reg <= px_x_reg;
            oy_reg <= px_y_reg;
            oc_reg <= color_reg;
            ol_reg <= last_reg;
        end
    end

    assign pix.valid      = ov_reg;
    assign pix.pixel_x    = ox_reg;
    assign pix.pixel_y    = oy_reg;
    assign pix.color      = oc_reg;
    assign pix.last_pixel = ol_reg;

    `TSR_ASSERT_IMP(a_row_within_limit, active_reg, row_reg <= limit_reg)
    `TSR_ASSERT_NXT(a_div_launch, div_start, div_busy)
    `TSR_ASSERT_IMP(a_idle_div_quiet, state_reg == ST_IDLE, !div_busy)

endmodule

FILE: tb/tsr_pixel_checker.sv
// Pixel checker for the rasterizer: tracks config and requests, predicts pixels, compares them
`timescale 1ns / 1ps

module tsr_pixel_checker (
    input  logic clk,
    input  logic rst_n,
    tsr_req_if   req,
    tsr_pix_if   pix,
    tsr_cfg_if   cfg,
    output int   errors,
    output int   pending
);
    import tsr_pkg::*;

    localparam int     PW   = COORD_INT_BITS;
    localparam int     VW   = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam longint FRAC = longint'(1) << COORD_FRAC_BITS;
    localparam longint FAR_LEFT = -(longint'(1) <<< 62);

    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic [COLOR_W-1:0]   color;
        logic                 last;
    } pixel_t;

    typedef struct {
        bit     ok;
        longint col_lo;
        longint col_hi;
        longint lx0, ly0, lx1, ly1;
        longint ux0, uy0, ux1, uy1;
    } half_t;

    logic signed [VW-1:0] vtx [6];
    logic [COLOR_W-1:0]   fill;

    longint cur_col, cur_row, row_top;
    int     cur_half;
    bit     walking;

    pixel_t expected_pixels [$];

    assign pending = expected_pixels.size();

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic longint cdiv(longint n, longint d);
        return -fdiv(-n, d);
    endfunction

    function automatic half_t half_bounds(int h);
        half_t  g;
        longint ax, ay, bx, by, cx, cy, tx, ty;
        bit     up;
        ax = longint'(vtx[0]); ay = longint'(vtx[1]);
        bx = longint'(vtx[2]); by = longint'(vtx[3]);
        cx = longint'(vtx[4]); cy = longint'(vtx[5]);
        if (bx < cx && bx < ax)
        begin
            tx = ax; ty = ay;
            ax = bx; ay = by; bx = cx; by = cy; cx = tx; cy = ty;
        end
        else if (cx < bx && cx < ax)
        begin
            tx = ax; ty = ay;
            ax = cx; ay = cy; cx = bx; cy = by; bx = tx; by = ty;
        end
        up = cx < bx;
        if (h == 0)
        begin
            g.ok = up ? (ax != cx) : (ax != bx && ax != cx);
            g.col_lo = cdiv(ax, FRAC);
            g.col_hi = fdiv(up ? cx : bx, FRAC);
            g.lx0 = ax; g.ly0 = ay; g.lx1 = bx; g.ly1 = by;
            g.ux0 = ax; g.uy0 = ay; g.ux1 = cx; g.uy1 = cy;
        end
        else
        begin
            g.ok = up ? 1'b1 : (bx != cx);
            g.col_lo = fdiv(up ? cx : bx, FRAC) + 1;
            g.col_hi = fdiv(up ? bx : cx, FRAC);
            if (up)
            begin
                g.lx0 = ax; g.ly0 = ay; g.lx1 = bx; g.ly1 = by;
                g.ux0 = cx; g.uy0 = cy; g.ux1 = bx; g.uy1 = by;
            end
            else
            begin
                g.lx0 = bx; g.ly0 = by; g.lx1 = cx; g.ly1 = cy;
                g.ux0 = ax; g.uy0 = ay; g.ux1 = cx; g.uy1 = cy;
            end
        end
        if (g.lx1 <= g.lx0 || g.ux1 <= g.ux0)
            g.ok = 1'b0;
        return g;
    endfunction

    // edge height at column i is num / (dx * FRAC)
    function automatic longint edge_num(longint x0, longint y0, longint x1, longint y1,
                                        longint i);
        return y0 * (x1 - x0) + (y1 - y0) * (i * FRAC - x0);
    endfunction

    function automatic bit find_column(int h, longint col);
        half_t  g;
        longint lo, hi;
        while (h <= 1)
        begin
            g = half_bounds(h);
            if (g.ok)
            begin
                if (col < g.col_lo)
                    col = g.col_lo;
                for (; col <= g.col_hi; col++)
                begin
                    lo = cdiv(edge_num(g.lx0, g.ly0, g.lx1, g.ly1, col), (g.lx1 - g.lx0) * FRAC);
                    hi = fdiv(edge_num(g.ux0, g.uy0, g.ux1, g.uy1, col), (g.ux1 - g.ux0) * FRAC);
                    if (lo <= hi)
                    begin
                        cur_half = h;
                        cur_col  = col;
                        cur_row  = lo;
                        row_top  = hi;
                        return 1'b1;
                    end
                end
            end
            h++;
            col = FAR_LEFT;
        end
        return 1'b0;
    endfunction

    function automatic void predict_tick(bit restart);
        pixel_t p;
        if (restart)
            walking = find_column(0, FAR_LEFT);
        if (!walking)
            return;
        p.x = cur_col[PW-1:0];
        p.y = cur_row[PW-1:0];
        p.color = fill;
        if (cur_row < row_top)
        begin
            cur_row++;
            walking = 1'b1;
        end
        else
            walking = find_column(cur_half, cur_col + 1);
        p.last = !walking;
        expected_pixels.push_back(p);
    endfunction

    initial
    begin
        errors = 0;
        foreach (vtx[k])
            vtx[k] = '0;
        fill = '0;
        cur_col = 0; cur_row = 0; row_top = 0; cur_half = 0; walking = 1'b0;
    end

    always @(posedge clk)
    begin
        pixel_t e;
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_FILL_COLOR)
                    fill = cfg.data[COLOR_W-1:0];
                else if (cfg.index <= REG_VERTEX_C_Y)
                    vtx[cfg.index] = cfg.data[VW-1:0];
            end
            if (req.valid && req.ready)
                predict_tick(req.start_req);
            if (pix.valid && pix.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected pixel x=%0d y=%0d", pix.pixel_x, pix.pixel_y);
                    errors++;
                end
                else
                begin
                    e = expected_pixels.pop_front();
                    if (pix.pixel_x !== e.x)
                    begin
                        $error("pixel_x: expected %0d, got %0d", e.x, pix.pixel_x);
                        errors++;
                    end
                    if (pix.pixel_y !== e.y)
                    begin
                        $error("pixel_y: expected %0d, got %0d", e.y, pix.pixel_y);
                        errors++;
                    end
                    if (pix.color !== e.color)
                    begin
                        $error("color: expected %h, got %h", e.color, pix.color);
                        errors++;
                    end
                    if (pix.last_pixel !== e.last)
                    begin
                        $error("last_pixel: expected %0b, got %0b", e.last, pix.last_pixel);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/triangle_scan_rasterizer_tb.sv
// Top of the rasterizer testbench: clock, reset, request and config stimulus, verdict
`timescale 1ns / 1ps

module triangle_scan_rasterizer_tb;
    import tsr_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int SETTLE       = 5000;
    localparam int TARGET_ITEMS = 1650;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   items_sent;
    int   burst_left;
    bit   hold_req;
    bit   hold_done;

    tsr_req_if req_ch ();
    tsr_pix_if pix_ch ();
    tsr_cfg_if cfg_ch ();

    triangle_scan_rasterizer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .pix   (pix_ch),
        .cfg   (cfg_ch)
    );

    tsr_pixel_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .pix     (pix_ch),
        .cfg     (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: stall modes, plus one long hold-off on request
    initial
    begin
        int cnt;
        int mode;
        pix_ch.ready = 1'b0;
        hold_done = 1'b0;
        cnt = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                pix_ch.ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_done = 1'b1;
            end
            if (cnt % 256 == 0)
                mode = $urandom_range(0, 2);
            cnt++;
            case (mode)
                0: pix_ch.ready <= 1'b1;
                1: pix_ch.ready <= $urandom_range(0, 1);
                default: pix_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic send_req(bit restart);
        req_ch.valid <= 1'b1;
        req_ch.start_req <= restart;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 5);
        end
        else
            burst_left--;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_triangle(logic signed [15:0] ax, logic signed [15:0] ay,
                                 logic signed [15:0] bx, logic signed [15:0] by,
                                 logic signed [15:0] cx, logic signed [15:0] cy,
                                 logic [23:0] rgb);
        logic [23:0] vals [7];
        vals[REG_VERTEX_A_X] = {8'h00, ax};
        vals[REG_VERTEX_A_Y] = {8'h00, ay};
        vals[REG_VERTEX_B_X] = {8'h00, bx};
        vals[REG_VERTEX_B_Y] = {8'h00, by};
        vals[REG_VERTEX_C_X] = {8'h00, cx};
        vals[REG_VERTEX_C_Y] = {8'h00, cy};
        vals[REG_FILL_COLOR] = rgb;
        for (int k = 0; k < 7; k++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= k[REG_IDX_W-1:0];
            cfg_ch.data <= vals[k];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // a start request, then ticks with an occasional restart
    task automatic run_walk(int n, int restart_pct);
        send_req(1'b1);
        for (int i = 1; i < n; i++)
            send_req($urandom_range(0, 99) < restart_pct);
    endtask

    task automatic random_triangle(int max_span);
        int span;
        logic signed [15:0] ox, oy;
        logic signed [15:0] v [6];
        span = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, max_span);
        ox = 16'(int'($urandom_range(0, 4000)) - 2000) * 16;
        oy = 16'(int'($urandom_range(0, 4000)) - 2000) * 16;
        for (int k = 0; k < 6; k += 2)
        begin
            v[k]   = ox + 16'($urandom_range(0, span * 16));
            v[k+1] = oy + 16'($urandom_range(0, span * 16));
        end
        if ($urandom_range(0, 4) == 0)
            v[2 * $urandom_range(0, 2)] = v[2 * $urandom_range(0, 2)];
        load_triangle(v[0], v[1], v[2], v[3], v[4], v[5], 24'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.start_req = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        hold_req = 1'b0;
        items_sent = 0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // upward, with a restart mid walk
        load_triangle(16'sd0, 16'sd0, 16'sd64, 16'sd16, 16'sd32, 16'sd64, 24'hFFFFFF);
        send_req(1'b1); send_req(1'b0); send_req(1'b0); send_req(1'b1); send_req(1'b0);
        drain();
        // downward
        load_triangle(16'sd0, 16'sd0, 16'sd32, 16'sd8, 16'sd48, 16'sd48, 24'h000000);
        run_walk(3, 0);
        drain();
        // upward with vertical left edge
        load_triangle(16'sd0, 16'sd0, 16'sd48, 16'sd16, 16'sd0, 16'sd48, 24'h123456);
        run_walk(2, 0);
        drain();
        // downward with vertical right edge
        load_triangle(16'sd0, 16'sd0, 16'sd48, 16'sd0, 16'sd48, 16'sd48, 24'hA5A5A5);
        run_walk(2, 0);
        drain();
        // leftmost tie between A and B keeps A first
        load_triangle(16'sd8, 16'sd40, 16'sd8, 16'sd0, 16'sd56, 16'sd24, 24'h5A5A5A);
        run_walk(2, 0);
        drain();
        // all vertices in one column: empty, then an idle tick
        load_triangle(16'sd0, -16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 24'h00FF00);
        run_walk(2, 0);
        drain();
        // thin sliver from the far left column
        load_triangle(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 16'sd32767, 16'sd16,
                      24'hFF0000);
        run_walk(2, 0);
        drain();
        load_triangle(16'sd32752, 16'sd0, 16'sd32767, 16'sd0, 16'sd32767, 16'sd16, 24'h0000FF);
        run_walk(1, 0);
        drain();
        load_triangle(16'sd0, 16'sd32752, 16'sd16, 16'sd32752, 16'sd16, 16'sd32767, 24'h00FFFF);
        run_walk(1, 0);
        drain();
        load_triangle(16'sd0, -16'sd32768, 16'sd16, -16'sd32768, 16'sd16, -16'sd32752,
                      24'hFF00FF);
        run_walk(1, 0);
        drain();

        // receiver held off while requests keep coming
        load_triangle(16'sd0, 16'sd0, 16'sd320, 16'sd0, 16'sd160, 16'sd320, 24'h808080);
        hold_req = 1'b1;
        burst_left = 60;
        run_walk(60, 0);
        drain();

        while (items_sent < TARGET_ITEMS)
        begin
            random_triangle(30);
            run_walk($urandom_range(10, 45), 8);
            drain();
        end

        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
